>>> rtl/cjp_pkg.sv
`timescale 1ns / 1ps

package cjp_pkg;

   localparam int Q_W       = 32;   // Q16.16 word
   localparam int QUOT_W    = 33;   // reciprocal quotient never exceeds 2^32
   localparam int DIV_STEPS = 33;
   localparam int MAG_W     = 49;   // rounded magnitude before clipping

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_APPLY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_APPLIED = 2'd0,
      STAT_STORED  = 2'd1,
      STAT_SKIPPED = 2'd2,
      STAT_CLEARED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_LOAD_SQ,
      S_LOAD_SUM,
      S_LOAD_START,
      S_LOAD_DIV,
      S_LOAD_WR,
      S_APPLY_RD,
      S_APPLY_MUL,
      S_APPLY_SUM,
      S_APPLY_OUT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic            sat;
      logic [Q_W-1:0]  value;
   } clip_type;

   // sign and magnitude to two's complement, saturating
   function automatic clip_type clip_q(input logic neg, input logic [MAG_W-1:0] mag);
      clip_type r;
      r.sat   = 1'b0;
      r.value = '0;
      if (!neg) begin
         if (mag > MAG_W'(32'h7FFF_FFFF)) begin
            r.sat   = 1'b1;
            r.value = 32'h7FFF_FFFF;
         end else begin
            r.value = mag[Q_W-1:0];
         end
      end else begin
         if (mag > MAG_W'(32'h8000_0000)) begin
            r.sat   = 1'b1;
            r.value = 32'h8000_0000;
         end else begin
            r.value = ~mag[Q_W-1:0] + 32'd1;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/cjp_req_if.sv
`timescale 1ns / 1ps

interface cjp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [11:0]        element_index;
   logic [11:0]        first_column;
   logic               row_empty;
   logic signed [31:0] value_re;
   logic signed [31:0] value_im;

   modport source (
      output valid, opcode, element_index, first_column, row_empty, value_re, value_im,
      input  ready
   );
   modport sink (
      input  valid, opcode, element_index, first_column, row_empty, value_re, value_im,
      output ready
   );
endinterface

>>> rtl/cjp_rsp_if.sv
`timescale 1ns / 1ps

interface cjp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_re;
   logic signed [31:0] result_im;
   logic [1:0]         status;
   logic               saturated;

   modport source (
      output valid, result_re, result_im, status, saturated,
      input  ready
   );
   modport sink (
      input  valid, result_re, result_im, status, saturated,
      output ready
   );
endinterface

>>> rtl/cjp_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Caller guarantees the
// quotient fits in QUOT_W bits and denom is nonzero.
module cjp_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [63:0]               numer,
   input  logic [63:0]               denom,
   output logic                      done,
   output logic [cjp_pkg::QUOT_W-1:0] quotient
);

   localparam logic [5:0] LAST_STEP = 6'(cjp_pkg::DIV_STEPS - 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [5:0]                 step_ff, step_in;
   logic [cjp_pkg::QUOT_W-1:0] num_ff, num_in;
   logic [cjp_pkg::QUOT_W-1:0] quo_ff, quo_in;
   logic [63:0]                den_ff, den_in;
   logic [63:0]                rem_ff, rem_in;
   logic [63:0]                shifted;
   logic                       fits;

   // remainder stays below denom <= 2^63, so its top bit is always clear
   assign shifted = {rem_ff[62:0], num_ff[cjp_pkg::QUOT_W-1]};
   assign fits    = shifted >= den_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = numer[cjp_pkg::QUOT_W-1:0];
         den_in  = denom;
         rem_in  = 64'(numer[63:cjp_pkg::QUOT_W]);
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? shifted - den_ff : shifted;
         quo_in  = {quo_ff[cjp_pkg::QUOT_W-2:0], fits};
         num_in  = {num_ff[cjp_pkg::QUOT_W-2:0], 1'b0};
         step_in = step_ff + 6'd1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/complex_jacobi_preconditioner.sv
`timescale 1ns / 1ps

// One item at a time; the next item is taken while a result waits in the output register.
// Apply in range: table read, multiply, sum, round, then the result; apply out of range,
// skipped load and unused opcode go straight to the result. Stored load: squares, sum, then
// the 33-step reciprocal dividers and the table write. Clear: one table row written per cycle.
// Reset (synchronous) zeroes rows_in_use and sweeps all MAX_ROWS rows to zero; no item is
// taken during the sweep.
module complex_jacobi_preconditioner #(
   parameter int MAX_ROWS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   cjp_req_if.sink     req_chan,
   cjp_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   localparam int              AW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [AW-1:0]   LAST_ROW = AW'(MAX_ROWS - 1);

   cjp_pkg::state_type state_ff, state_in;
   logic [12:0]        rows_ff, rows_in;
   logic [AW-1:0]      clear_cnt_ff, clear_cnt_in;
   logic               clear_report_ff, clear_report_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // item registers
   logic [11:0]        idx_ff;
   logic signed [31:0] a_ff, b_ff;
   logic [31:0]        mag_a_ff, mag_b_ff;

   // datapath registers
   logic [63:0]        sq_a_ff, sq_b_ff, den_ff;
   logic [63:0]        rd_data_ff;
   logic signed [63:0] p_ca_ff, p_db_ff, p_cb_ff, p_da_ff;
   logic signed [64:0] sum_re_ff, sum_im_ff;

   // pending result and output register
   logic [31:0]        res_re_ff, res_im_ff;
   cjp_pkg::status_type res_status_ff;
   logic               res_sat_ff;
   logic [31:0]        rsp_re_ff, rsp_im_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_sat_ff;

   logic [63:0]        table_mem [MAX_ROWS];

   logic               req_fire, out_free, out_load;
   logic               load_ok, apply_hit;
   logic [31:0]        req_mag_a, req_mag_b;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [63:0]        mem_wdata;
   logic               div_start, div_done_re, div_done_im;
   logic [63:0]        numer_re, numer_im;
   logic [cjp_pkg::QUOT_W-1:0] quo_re, quo_im;
   cjp_pkg::clip_type  clip_rr, clip_ri, clip_yr, clip_yi;
   logic [63:0]        mag_yr, mag_yi;
   logic [64:0]        rnd_yr, rnd_yi;
   logic signed [31:0] tab_c, tab_d;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_mag_a = 32'(-req_chan.value_re);
   assign req_mag_b = 32'(-req_chan.value_im);

   assign load_ok = !req_chan.row_empty
                    && (req_chan.first_column == req_chan.element_index)
                    && (32'(req_chan.element_index) < MAX_ROWS)
                    && ((req_chan.value_re != 32'sd0) || (req_chan.value_im != 32'sd0));
   assign apply_hit = (32'(req_chan.element_index) < 32'(rows_ff))
                      && (32'(req_chan.element_index) < MAX_ROWS);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cjp_pkg::S_IDLE: begin
            if (req_fire) begin
               case (cjp_pkg::op_type'(req_chan.opcode))
                  cjp_pkg::OP_CLEAR: state_in = cjp_pkg::S_CLEAR;
                  cjp_pkg::OP_LOAD:  state_in = load_ok ? cjp_pkg::S_LOAD_SQ : cjp_pkg::S_DONE;
                  cjp_pkg::OP_APPLY: state_in = apply_hit ? cjp_pkg::S_APPLY_RD
                                                          : cjp_pkg::S_DONE;
                  default:           state_in = cjp_pkg::S_DONE;
               endcase
            end
         end
         cjp_pkg::S_CLEAR: begin
            if (clear_cnt_ff == LAST_ROW) begin
               state_in = clear_report_ff ? cjp_pkg::S_DONE : cjp_pkg::S_IDLE;
            end
         end
         cjp_pkg::S_LOAD_SQ:    state_in = cjp_pkg::S_LOAD_SUM;
         cjp_pkg::S_LOAD_SUM:   state_in = cjp_pkg::S_LOAD_START;
         cjp_pkg::S_LOAD_START: state_in = cjp_pkg::S_LOAD_DIV;
         cjp_pkg::S_LOAD_DIV: begin
            // both dividers run in lockstep
            if (div_done_re && div_done_im) begin
               state_in = cjp_pkg::S_LOAD_WR;
            end
         end
         cjp_pkg::S_LOAD_WR:    state_in = cjp_pkg::S_DONE;
         cjp_pkg::S_APPLY_RD:   state_in = cjp_pkg::S_APPLY_MUL;
         cjp_pkg::S_APPLY_MUL:  state_in = cjp_pkg::S_APPLY_SUM;
         cjp_pkg::S_APPLY_SUM:  state_in = cjp_pkg::S_APPLY_OUT;
         cjp_pkg::S_APPLY_OUT:  state_in = cjp_pkg::S_DONE;
         cjp_pkg::S_DONE: begin
            if (out_free) begin
               state_in = cjp_pkg::S_IDLE;
            end
         end
         default: state_in = cjp_pkg::S_IDLE;
      endcase
   end

   // ---------------- outputs ----------------
   always_comb begin
      req_chan.ready  = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = AW'(idx_ff);
      mem_wdata       = {clip_ri.value, clip_rr.value};
      div_start       = 1'b0;
      out_load        = 1'b0;
      clear_cnt_in    = '0;
      clear_report_in = clear_report_ff;
      case (state_ff)
         cjp_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_fire) begin
               clear_report_in = 1'b1;
            end
         end
         cjp_pkg::S_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = clear_cnt_ff;
            mem_wdata    = '0;
            clear_cnt_in = clear_cnt_ff + AW'(1);
         end
         cjp_pkg::S_LOAD_START: div_start = 1'b1;
         cjp_pkg::S_LOAD_WR:    mem_we    = 1'b1;
         cjp_pkg::S_DONE:       out_load  = out_free;
         default: ;
      endcase
   end

   assign rows_in      = csr_we ? csr_wdata : rows_ff;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cjp_pkg::S_CLEAR;
         rows_ff         <= '0;
         clear_cnt_ff    <= '0;
         clear_report_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rows_ff         <= rows_in;
         clear_cnt_ff    <= clear_cnt_in;
         clear_report_ff <= clear_report_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ---------------- inverse table ----------------
   assign mem_raddr = AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[mem_raddr];
   end

   // ---------------- reciprocal ----------------
   assign numer_re = {mag_a_ff, 32'd0} + {1'b0, den_ff[63:1]};
   assign numer_im = {mag_b_ff, 32'd0} + {1'b0, den_ff[63:1]};

   cjp_divider u_div_re (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer_re),
      .denom    (den_ff),
      .done     (div_done_re),
      .quotient (quo_re)
   );

   cjp_divider u_div_im (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer_im),
      .denom    (den_ff),
      .done     (div_done_im),
      .quotient (quo_im)
   );

   // imaginary part of the reciprocal carries the opposite sign of b
   assign clip_rr = cjp_pkg::clip_q(a_ff < 32'sd0, cjp_pkg::MAG_W'(quo_re));
   assign clip_ri = cjp_pkg::clip_q(b_ff > 32'sd0, cjp_pkg::MAG_W'(quo_im));

   // ---------------- apply ----------------
   assign tab_c = rd_data_ff[31:0];
   assign tab_d = rd_data_ff[63:32];

   assign mag_yr  = sum_re_ff[64] ? 64'(-sum_re_ff) : 64'(sum_re_ff);
   assign mag_yi  = sum_im_ff[64] ? 64'(-sum_im_ff) : 64'(sum_im_ff);
   assign rnd_yr  = {1'b0, mag_yr} + 65'h8000;
   assign rnd_yi  = {1'b0, mag_yi} + 65'h8000;
   assign clip_yr = cjp_pkg::clip_q(sum_re_ff[64], rnd_yr[64:16]);
   assign clip_yi = cjp_pkg::clip_q(sum_im_ff[64], rnd_yi[64:16]);

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         idx_ff     <= req_chan.element_index;
         a_ff       <= req_chan.value_re;
         b_ff       <= req_chan.value_im;
         mag_a_ff   <= req_chan.value_re[31] ? req_mag_a : req_chan.value_re;
         mag_b_ff   <= req_chan.value_im[31] ? req_mag_b : req_chan.value_im;
         res_re_ff  <= '0;
         res_im_ff  <= '0;
         res_sat_ff <= 1'b0;
         case (cjp_pkg::op_type'(req_chan.opcode))
            cjp_pkg::OP_CLEAR: res_status_ff <= cjp_pkg::STAT_CLEARED;
            cjp_pkg::OP_APPLY: begin
               // pass-through unless the table row is used
               res_status_ff <= cjp_pkg::STAT_APPLIED;
               res_re_ff     <= req_chan.value_re;
               res_im_ff     <= req_chan.value_im;
            end
            default: res_status_ff <= cjp_pkg::STAT_SKIPPED;
         endcase
      end
      case (state_ff)
         cjp_pkg::S_LOAD_SQ: begin
            sq_a_ff <= mag_a_ff * mag_a_ff;
            sq_b_ff <= mag_b_ff * mag_b_ff;
         end
         cjp_pkg::S_LOAD_SUM: den_ff <= sq_a_ff + sq_b_ff;
         cjp_pkg::S_LOAD_WR: begin
            res_status_ff <= cjp_pkg::STAT_STORED;
            res_sat_ff    <= clip_rr.sat || clip_ri.sat;
         end
         cjp_pkg::S_APPLY_MUL: begin
            p_ca_ff <= tab_c * a_ff;
            p_db_ff <= tab_d * b_ff;
            p_cb_ff <= tab_c * b_ff;
            p_da_ff <= tab_d * a_ff;
         end
         cjp_pkg::S_APPLY_SUM: begin
            sum_re_ff <= 65'(p_ca_ff) - 65'(p_db_ff);
            sum_im_ff <= 65'(p_cb_ff) + 65'(p_da_ff);
         end
         cjp_pkg::S_APPLY_OUT: begin
            res_re_ff  <= clip_yr.value;
            res_im_ff  <= clip_yi.value;
            res_sat_ff <= clip_yr.sat || clip_yi.sat;
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_re_ff     <= res_re_ff;
         rsp_im_ff     <= res_im_ff;
         rsp_status_ff <= res_status_ff;
         rsp_sat_ff    <= res_sat_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.result_re = rsp_re_ff;
   assign rsp_chan.result_im = rsp_im_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

endmodule
